// ----- rtl/core/v3a_pkg.sv -----
// Shared constants, opcodes and pipeline types of the 3D vector arithmetic unit.
package v3a_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 64;
  localparam int WIDE_W      = 66;
  localparam int ROOT_W      = 32;
  localparam int SQRT_STAGES = 32;
  localparam int NUM_W       = 64;
  localparam int QUO_W       = FRAC_BITS + 1;
  localparam int DIV_STAGES  = QUO_W;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_DOT      = 4'd2,
    OP_SCALE    = 4'd3,
    OP_CROSS    = 4'd4,
    OP_LENGTH   = 4'd5,
    OP_NORM     = 4'd6,
    OP_IS_ZERO  = 4'd7,
    OP_IS_EQUAL = 4'd8
  } op_t;

  typedef struct packed {
    logic [3:0]                   op;
    logic signed [DATA_W-1:0]     res_x;
    logic signed [DATA_W-1:0]     res_y;
    logic signed [DATA_W-1:0]     res_z;
    logic signed [DATA_W-1:0]     res_scalar;
    logic                         flag;
    logic                         sat;
    logic                         zero_len;
    logic [2:0]                   neg;
    logic [2:0][DATA_W-1:0]       mag;
  } side_t;

endpackage

// ----- rtl/core/v3a_isqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
module v3a_isqrt import v3a_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [PROD_W-1:0] radicand,
  output logic [ROOT_W-1:0] root
);

  logic [PROD_W-1:0] rem_r [SQRT_STAGES];
  logic [PROD_W-1:0] acc_r [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [PROD_W-1:0] BIT_K = PROD_W'(1) << (2 * (SQRT_STAGES - 1 - k));
    logic [PROD_W-1:0] rem_in;
    logic [PROD_W-1:0] acc_in;
    logic [PROD_W-1:0] trial;
    logic [PROD_W-1:0] rem_nxt;
    logic [PROD_W-1:0] acc_nxt;

    if (k == 0) begin : g_first
      assign rem_in = radicand;
      assign acc_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    always_comb begin
      trial = acc_in + BIT_K;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        acc_nxt = (acc_in >> 1) + BIT_K;
      end else begin
        rem_nxt = rem_in;
        acc_nxt = acc_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        acc_r[k] <= acc_nxt;
      end
    end
  end

  assign root = acc_r[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

// ----- rtl/core/v3a_udiv.sv -----
// Pipelined restoring unsigned divider, one quotient bit per register stage.
module v3a_udiv import v3a_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic [QUO_W-1:0]  quo
);

  logic [NUM_W-1:0]  rem_r [DIV_STAGES];
  logic [ROOT_W-1:0] den_r [DIV_STAGES];
  logic [QUO_W-1:0]  quo_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int SH = DIV_STAGES - 1 - k;
    logic [NUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] den_in;
    logic [QUO_W-1:0]  quo_in;
    logic [NUM_W-1:0]  dsh;
    logic [NUM_W-1:0]  rem_nxt;
    logic [QUO_W-1:0]  quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      dsh = NUM_W'(den_in) << SH;
      if (rem_in >= dsh) begin
        rem_nxt = rem_in - dsh;
        quo_nxt = quo_in | (QUO_W'(1) << SH);
      end else begin
        rem_nxt = rem_in;
        quo_nxt = quo_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

// ----- rtl/core/vector3_alu.sv -----
// 3D vector arithmetic unit on signed Q16.16 vectors with saturation.
// The unit accepts one transfer per cycle while out_ready stays high and returns one result
// per transfer, in order. Each operation passes the input, product, sum and saturation stages,
// then the 32-stage square-root pipeline, which delivers one root bit per stage, followed by
// the normalize divider with one quotient bit per stage, and the output register. Every
// operation travels the full pipeline, so results never reorder. When a result waits in the
// output register with out_ready low, the whole pipeline holds and in_ready drops with it.
module vector3_alu import v3a_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [3:0]               in_op,
  input  logic signed [DATA_W-1:0] in_a_x,
  input  logic signed [DATA_W-1:0] in_a_y,
  input  logic signed [DATA_W-1:0] in_a_z,
  input  logic signed [DATA_W-1:0] in_b_x,
  input  logic signed [DATA_W-1:0] in_b_y,
  input  logic signed [DATA_W-1:0] in_b_z,
  input  logic signed [DATA_W-1:0] in_scale_factor,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_res_x,
  output logic signed [DATA_W-1:0] out_res_y,
  output logic signed [DATA_W-1:0] out_res_z,
  output logic signed [DATA_W-1:0] out_res_scalar,
  output logic                     out_res_flag,
  output logic                     out_saturated,
  output logic                     out_zero_length
);

  localparam logic signed [WIDE_W-1:0] MAX_W = WIDE_W'(32'sh7fffffff);
  localparam logic signed [WIDE_W-1:0] MIN_W = WIDE_W'(32'sh80000000);

  function automatic logic [DATA_W:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [DATA_W:0] r;
    if (v > MAX_W) begin
      r = {1'b1, 32'h7fffffff};
    end else if (v < MIN_W) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: input register.
  logic                     s1_vld_r;
  logic [3:0]               s1_op_r;
  logic signed [DATA_W-1:0] s1_a_r [3];
  logic signed [DATA_W-1:0] s1_b_r [3];
  logic signed [DATA_W-1:0] s1_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r   <= in_op;
      s1_a_r[0] <= in_a_x;
      s1_a_r[1] <= in_a_y;
      s1_a_r[2] <= in_a_z;
      s1_b_r[0] <= in_b_x;
      s1_b_r[1] <= in_b_y;
      s1_b_r[2] <= in_b_z;
      s1_s_r    <= in_scale_factor;
    end
  end

  // Stage 2: products, add/sub, compare flags, magnitudes.
  logic signed [DATA_W-1:0] mul_a [3];
  logic signed [DATA_W-1:0] mul_b [3];
  logic signed [PROD_W-1:0] s2_prod_nxt [6];
  logic signed [DATA_W:0]   s2_as_nxt [3];
  logic                     s2_flag_nxt;
  logic [2:0]               s2_neg_nxt;
  logic [DATA_W-1:0]        s2_mag_nxt [3];

  always_comb begin
    mul_a[0] = s1_a_r[0];
    mul_b[0] = s1_b_r[0];
    mul_a[1] = s1_a_r[1];
    mul_b[1] = s1_b_r[1];
    mul_a[2] = s1_a_r[2];
    mul_b[2] = s1_b_r[2];
    s2_flag_nxt = 1'b0;
    case (op_t'(s1_op_r))
      OP_SCALE: begin
        mul_a[0] = s1_s_r;
        mul_b[0] = s1_a_r[0];
        mul_a[1] = s1_s_r;
        mul_b[1] = s1_a_r[1];
        mul_a[2] = s1_s_r;
        mul_b[2] = s1_a_r[2];
      end
      OP_CROSS: begin
        mul_a[0] = s1_a_r[1];
        mul_b[0] = s1_b_r[2];
        mul_a[1] = s1_a_r[2];
        mul_b[1] = s1_b_r[0];
        mul_a[2] = s1_a_r[0];
        mul_b[2] = s1_b_r[1];
      end
      OP_LENGTH, OP_NORM: begin
        mul_b[0] = s1_a_r[0];
        mul_b[1] = s1_a_r[1];
        mul_b[2] = s1_a_r[2];
      end
      OP_IS_ZERO: begin
        s2_flag_nxt = (s1_a_r[0] == '0) && (s1_a_r[1] == '0) && (s1_a_r[2] == '0);
      end
      OP_IS_EQUAL: begin
        s2_flag_nxt = (s1_a_r[0] == s1_b_r[0]) && (s1_a_r[1] == s1_b_r[1]) &&
                      (s1_a_r[2] == s1_b_r[2]);
      end
      default: begin
      end
    endcase
  end

  for (genvar j = 0; j < 3; j++) begin : g_s2
    assign s2_prod_nxt[j] = mul_a[j] * mul_b[j];
    assign s2_as_nxt[j]   = (op_t'(s1_op_r) == OP_SUB) ?
                            ((DATA_W+1)'(s1_a_r[j]) - (DATA_W+1)'(s1_b_r[j])) :
                            ((DATA_W+1)'(s1_a_r[j]) + (DATA_W+1)'(s1_b_r[j]));
    assign s2_neg_nxt[j]  = s1_a_r[j][DATA_W-1];
    assign s2_mag_nxt[j]  = s1_a_r[j][DATA_W-1] ? (~s1_a_r[j] + 1'b1) : s1_a_r[j];
  end

  assign s2_prod_nxt[3] = s1_a_r[2] * s1_b_r[1];
  assign s2_prod_nxt[4] = s1_a_r[0] * s1_b_r[2];
  assign s2_prod_nxt[5] = s1_a_r[1] * s1_b_r[0];

  logic                     s2_vld_r;
  logic [3:0]               s2_op_r;
  logic signed [PROD_W-1:0] s2_prod_r [6];
  logic signed [DATA_W:0]   s2_as_r [3];
  logic                     s2_flag_r;
  logic [2:0]               s2_neg_r;
  logic [DATA_W-1:0]        s2_mag_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op_r   <= s1_op_r;
      s2_prod_r <= s2_prod_nxt;
      s2_as_r   <= s2_as_nxt;
      s2_flag_r <= s2_flag_nxt;
      s2_neg_r  <= s2_neg_nxt;
      s2_mag_r  <= s2_mag_nxt;
    end
  end

  // Stage 3: exact sums before scaling, and the squared length.
  logic signed [WIDE_W-1:0] s3_w_nxt [4];
  logic [PROD_W-1:0]        s3_sq_nxt;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      s3_w_nxt[j] = '0;
    end
    case (op_t'(s2_op_r))
      OP_ADD, OP_SUB: begin
        for (int j = 0; j < 3; j++) begin
          s3_w_nxt[j] = WIDE_W'(s2_as_r[j]);
        end
      end
      OP_DOT: begin
        s3_w_nxt[3] = WIDE_W'(s2_prod_r[0]) + WIDE_W'(s2_prod_r[1]) + WIDE_W'(s2_prod_r[2]);
      end
      OP_SCALE: begin
        for (int j = 0; j < 3; j++) begin
          s3_w_nxt[j] = WIDE_W'(s2_prod_r[j]);
        end
      end
      OP_CROSS: begin
        for (int j = 0; j < 3; j++) begin
          s3_w_nxt[j] = WIDE_W'(s2_prod_r[j]) - WIDE_W'(s2_prod_r[j+3]);
        end
      end
      default: begin
      end
    endcase
  end

  assign s3_sq_nxt = $unsigned(s2_prod_r[0]) + $unsigned(s2_prod_r[1]) +
                     $unsigned(s2_prod_r[2]);

  logic                     s3_vld_r;
  logic [3:0]               s3_op_r;
  logic signed [WIDE_W-1:0] s3_w_r [4];
  logic [PROD_W-1:0]        s3_sq_r;
  logic                     s3_flag_r;
  logic [2:0]               s3_neg_r;
  logic [DATA_W-1:0]        s3_mag_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_op_r   <= s2_op_r;
      s3_w_r    <= s3_w_nxt;
      s3_sq_r   <= s3_sq_nxt;
      s3_flag_r <= s2_flag_r;
      s3_neg_r  <= s2_neg_r;
      s3_mag_r  <= s2_mag_r;
    end
  end

  // Stage 4: floor shift and saturation.
  logic signed [WIDE_W-1:0] s4_sh [4];
  logic [DATA_W:0]          s4_sat [4];
  side_t                    s4_side_nxt;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if ((op_t'(s3_op_r) == OP_ADD) || (op_t'(s3_op_r) == OP_SUB)) begin
        s4_sh[j] = s3_w_r[j];
      end else begin
        s4_sh[j] = s3_w_r[j] >>> FRAC_BITS;
      end
      s4_sat[j] = sat32(s4_sh[j]);
    end
    s4_side_nxt.op         = s3_op_r;
    s4_side_nxt.res_x      = s4_sat[0][DATA_W-1:0];
    s4_side_nxt.res_y      = s4_sat[1][DATA_W-1:0];
    s4_side_nxt.res_z      = s4_sat[2][DATA_W-1:0];
    s4_side_nxt.res_scalar = s4_sat[3][DATA_W-1:0];
    s4_side_nxt.flag       = s3_flag_r;
    s4_side_nxt.sat        = s4_sat[0][DATA_W] | s4_sat[1][DATA_W] |
                             s4_sat[2][DATA_W] | s4_sat[3][DATA_W];
    s4_side_nxt.zero_len   = 1'b0;
    s4_side_nxt.neg        = s3_neg_r;
    for (int j = 0; j < 3; j++) begin
      s4_side_nxt.mag[j] = s3_mag_r[j];
    end
  end

  logic              s4_vld_r;
  side_t             s4_side_r;
  logic [PROD_W-1:0] s4_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= s4_side_nxt;
      s4_sq_r   <= s3_sq_r;
    end
  end

  // Square root stages with the side data traveling alongside.
  logic [ROOT_W-1:0] root;
  logic              sq_vld_r  [SQRT_STAGES];
  side_t             sq_side_r [SQRT_STAGES];

  v3a_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s4_sq_r),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        sq_vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      sq_vld_r[0] <= s4_vld_r;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sq_vld_r[k] <= sq_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0] <= s4_side_r;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sq_side_r[k] <= sq_side_r[k-1];
      end
    end
  end

  // Length result and divider inputs.
  side_t            dv_side_nxt;
  logic [NUM_W-1:0] dv_num [3];

  always_comb begin
    dv_side_nxt = sq_side_r[SQRT_STAGES-1];
    case (op_t'(dv_side_nxt.op))
      OP_LENGTH: begin
        dv_side_nxt.res_scalar = root[ROOT_W-1] ? 32'sh7fffffff : $signed(root);
        dv_side_nxt.sat        = root[ROOT_W-1];
      end
      OP_NORM: begin
        dv_side_nxt.zero_len = (root == '0);
      end
      default: begin
      end
    endcase
  end

  logic [QUO_W-1:0] quo [3];

  for (genvar j = 0; j < 3; j++) begin : g_div
    assign dv_num[j] = NUM_W'(sq_side_r[SQRT_STAGES-1].mag[j]) << FRAC_BITS;

    v3a_udiv u_udiv (
      .clk (clk),
      .en  (en),
      .num (dv_num[j]),
      .den (root),
      .quo (quo[j])
    );
  end

  logic  dv_vld_r  [DIV_STAGES];
  side_t dv_side_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      dv_vld_r[0] <= sq_vld_r[SQRT_STAGES-1];
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0] <= dv_side_nxt;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  // Output register.
  side_t                    fin;
  logic signed [DATA_W-1:0] nrm [3];
  logic signed [DATA_W-1:0] res_x_nxt;
  logic signed [DATA_W-1:0] res_y_nxt;
  logic signed [DATA_W-1:0] res_z_nxt;

  assign fin = dv_side_r[DIV_STAGES-1];

  for (genvar j = 0; j < 3; j++) begin : g_nrm
    assign nrm[j] = fin.neg[j] ? -$signed(DATA_W'(quo[j])) : $signed(DATA_W'(quo[j]));
  end

  always_comb begin
    res_x_nxt = fin.res_x;
    res_y_nxt = fin.res_y;
    res_z_nxt = fin.res_z;
    if ((op_t'(fin.op) == OP_NORM) && !fin.zero_len) begin
      res_x_nxt = nrm[0];
      res_y_nxt = nrm[1];
      res_z_nxt = nrm[2];
    end
  end

  logic signed [DATA_W-1:0] out_res_x_r;
  logic signed [DATA_W-1:0] out_res_y_r;
  logic signed [DATA_W-1:0] out_res_z_r;
  logic signed [DATA_W-1:0] out_res_scalar_r;
  logic                     out_res_flag_r;
  logic                     out_saturated_r;
  logic                     out_zero_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_x_r       <= res_x_nxt;
      out_res_y_r       <= res_y_nxt;
      out_res_z_r       <= res_z_nxt;
      out_res_scalar_r  <= fin.res_scalar;
      out_res_flag_r    <= fin.flag;
      out_saturated_r   <= fin.sat;
      out_zero_length_r <= fin.zero_len;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_x       = out_res_x_r;
  assign out_res_y       = out_res_y_r;
  assign out_res_z       = out_res_z_r;
  assign out_res_scalar  = out_res_scalar_r;
  assign out_res_flag    = out_res_flag_r;
  assign out_saturated   = out_saturated_r;
  assign out_zero_length = out_zero_length_r;

endmodule

// ----- rtl/core/v3a_checker.sv -----
// Port-level assertions for the 3D vector arithmetic unit and their bind.
module v3a_checker import v3a_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_res_x,
  input logic signed [DATA_W-1:0] out_res_y,
  input logic signed [DATA_W-1:0] out_res_z,
  input logic signed [DATA_W-1:0] out_res_scalar,
  input logic                     out_res_flag,
  input logic                     out_saturated,
  input logic                     out_zero_length
);

  // A result that waits for its transfer stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_x) && $stable(out_res_y) &&
      $stable(out_res_z) && $stable(out_res_scalar) && $stable(out_res_flag) &&
      $stable(out_saturated) && $stable(out_zero_length))
    else $error("result changed while stalled");

  // Normalizing a zero vector gives all zero outputs and no other flag.
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> out_res_x == '0 && out_res_y == '0 &&
      out_res_z == '0 && out_res_scalar == '0 && !out_res_flag && !out_saturated)
    else $error("zero-length result not cleared");

  // A true test result carries no numeric result and no clipping.
  a_flag_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res_flag |-> out_res_x == '0 && out_res_y == '0 &&
      out_res_z == '0 && out_res_scalar == '0 && !out_saturated && !out_zero_length)
    else $error("test result mixed with numeric result");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind vector3_alu v3a_checker u_v3a_checker (.*);
